@@ sv/sorted_accumulating_key_table_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted accumulating key table
// Clocked on clk_i; the first form is gated off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_ACCUMULATING_KEY_TABLE_CORE_MACROS_SVH
`define SORTED_ACCUMULATING_KEY_TABLE_CORE_MACROS_SVH

// Check a property outside of reset
`define SAKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every clock edge, reset included
`define SAKT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/sakt_pkg.sv @@
// ----------------------------------------------------------------------------
// sakt_pkg
// Types and constants shared by the sorted accumulating key table.
// ----------------------------------------------------------------------------
`default_nettype none

package sakt_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 16;
  localparam int AMT_W    = 16;
  localparam int SUM_W    = 32;
  localparam int OCC_W    = 7;

  typedef enum logic {
    OP_ADD     = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STAT_UPDATED   = 3'd0,
    STAT_INSERTED  = 3'd1,
    STAT_DROPPED   = 3'd2,
    STAT_EXTRACTED = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    op_e                     op;
    logic [KEY_W-1:0]        key;
    logic signed [AMT_W-1:0] amount;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic [KEY_W-1:0]        out_key;
    logic signed [SUM_W-1:0] out_sum;
    logic [OCC_W-1:0]        occupancy;
  } res_t;

  // One table entry held by a cell
  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [SUM_W-1:0] sum;
  } entry_t;

  // Row-wide command to the cells
  typedef struct packed {
    logic insert;
    logic extract;
    logic update;
  } ctrl_t;

  // Per-cell compare flags
  typedef struct packed {
    logic pos;  // entry empty or key not below the search key
    logic eq;   // entry valid and key equal to the search key
  } flag_t;

endpackage

`default_nettype wire

@@ sv/sakt_cell.sv @@
// ----------------------------------------------------------------------------
// sakt_cell
// One slot of the sorted row: compares its key against the broadcast key and
// moves its entry left or right along the row on insert and extract.
// ----------------------------------------------------------------------------
`default_nettype none

module sakt_cell
  import sakt_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire ctrl_t                   ctrl_i,
  input  wire logic                    valid_i,
  input  wire logic [KEY_W-1:0]        key_cmp_i,
  input  wire logic signed [SUM_W-1:0] new_sum_i,
  input  wire logic                    pos_left_i,
  input  wire logic                    sel_i,
  input  wire entry_t                  left_i,
  input  wire entry_t                  right_i,
  output entry_t                       entry_o,
  output flag_t                        flag_o
);

  entry_t entry_q;
  entry_t entry_d;

  // Compare against the broadcast key
  assign flag_o.pos = !valid_i || (entry_q.key >= key_cmp_i);
  assign flag_o.eq  = valid_i && (entry_q.key == key_cmp_i);
  assign entry_o    = entry_q;

  // Pick next entry: shift right on insert, shift left on extract, new sum on a selected update
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (pos_left_i) begin
        entry_d = left_i;
      end else if (flag_o.pos) begin
        entry_d.key = key_cmp_i;
        entry_d.sum = new_sum_i;
      end
    end else if (ctrl_i.extract) begin
      entry_d = right_i;
    end else if (ctrl_i.update && sel_i) begin
      entry_d.sum = new_sum_i;
    end
  end

  // Hold entry payload
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

@@ sv/sorted_accumulating_key_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_accumulating_key_table_core
// Sorted (key, sum) table built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// A request passes ST_CMP; an add to a present key also passes ST_UPD,
// which adds and saturates in a second pass. Result and done_o are
// registered at the end of the last state; new requests are taken in ST_IDLE
// only. Cells compare together in ST_CMP and shift together at its end.
// Reset clears state, count and done only; no clearing pass. The receiver
// cannot stall: each result shows for exactly one cycle with done_o.
`default_nettype none

module sorted_accumulating_key_table_core
  import sakt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output res_t      res_o
);

`include "sorted_accumulating_key_table_core_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  req_t                    req_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CAPACITY-1:0]     match_q;
  logic signed [SUM_W-1:0] old_sum_q;
  res_t                    res_q, res_d;
  logic                    done_q, done_d;

  ctrl_t                   ctrl;
  logic signed [SUM_W-1:0] new_sum;
  logic signed [SUM_W-1:0] sel_sum;
  logic signed [SUM_W:0]   wide_sum;
  logic signed [SUM_W-1:0] sat_sum;
  logic signed [SUM_W-1:0] amt_ext;
  logic [CAPACITY-1:0]     eq_vec;
  logic [CAPACITY-1:0]     valid_w;
  logic                    any_match;
  logic                    full;
  entry_t                  entry_w [CAPACITY];
  flag_t                   flag_w  [CAPACITY];

  assign amt_ext = SUM_W'(req_q.amount);
  assign full    = (count_q == CNT_W'(CAPACITY));

  // Mark cells below the entry count as live
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_w[i] = (CNT_W'(i) < count_q);
      eq_vec[i]  = flag_w[i].eq;
    end
  end

  assign any_match = |eq_vec;

  // Gather the sum of the matching cell
  always_comb begin
    sel_sum = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_sum = sel_sum | (eq_vec[i] ? entry_w[i].sum : '0);
    end
  end

  // Add and saturate to the signed limits
  always_comb begin
    wide_sum = (SUM_W+1)'(old_sum_q) + (SUM_W+1)'(req_q.amount);
    if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
      sat_sum = wide_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_sum = wide_sum[SUM_W-1:0];
    end
  end

  assign new_sum = state_q == ST_UPD ? sat_sum : amt_ext;

  // Sequence one request
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    res_d   = res_q;
    done_d  = 1'b0;
    ctrl    = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d       = ST_IDLE;
        done_d        = 1'b1;
        res_d.out_key = req_q.key;
        res_d.out_sum = '0;
        if (req_q.op == OP_EXTRACT) begin
          if (count_q == '0) begin
            res_d.status = STAT_EMPTY;
          end else begin
            ctrl.extract  = 1'b1;
            count_d       = count_q - CNT_W'(1);
            res_d.status  = STAT_EXTRACTED;
            res_d.out_key = entry_w[0].key;
            res_d.out_sum = entry_w[0].sum;
          end
        end else if (any_match) begin
          state_d = ST_UPD;
          done_d  = 1'b0;
        end else if (full) begin
          res_d.status = STAT_DROPPED;
        end else begin
          ctrl.insert   = 1'b1;
          count_d       = count_q + CNT_W'(1);
          res_d.status  = STAT_INSERTED;
          res_d.out_sum = amt_ext;
        end
        res_d.occupancy = OCC_W'(count_d);
      end
      ST_UPD: begin
        state_d         = ST_IDLE;
        done_d          = 1'b1;
        ctrl.update     = 1'b1;
        res_d.status    = STAT_UPDATED;
        res_d.out_key   = req_q.key;
        res_d.out_sum   = sat_sum;
        res_d.occupancy = OCC_W'(count_q);
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Hold request, match vector, old sum and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      req_q <= req_i;
    end
    if (state_q == ST_CMP) begin
      match_q   <= eq_vec;
      old_sum_q <= sel_sum;
    end
    res_q <= res_d;
  end

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_w;
    entry_t right_w;
    logic   pos_left_w;

    if (g == 0) begin : g_head
      assign left_w     = '0;
      assign pos_left_w = 1'b0;
    end else begin : g_body
      assign left_w     = entry_w[g-1];
      assign pos_left_w = flag_w[g-1].pos;
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = entry_w[g];
    end else begin : g_next
      assign right_w = entry_w[g+1];
    end

    sakt_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (valid_w[g]),
      .key_cmp_i  (req_q.key),
      .new_sum_i  (new_sum),
      .pos_left_i (pos_left_w),
      .sel_i      (match_q[g]),
      .left_i     (left_w),
      .right_i    (right_w),
      .entry_o    (entry_w[g]),
      .flag_o     (flag_w[g])
    );
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // Checks
  `SAKT_ASSERT(a_count_cap, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `SAKT_ASSERT(a_one_match, state_q == ST_CMP |-> $onehot0(eq_vec), "more than one key match")
  `SAKT_ASSERT(a_done_after_busy, done_o |-> $past(busy_o), "result strobe without a request")
  `SAKT_ASSERT(a_count_step, count_q != $past(count_q) |-> $past(state_q == ST_CMP), "count moved outside compare")

endmodule

`default_nettype wire
